// ===== rtl/core/pup_pkg.sv =====
package pup_pkg;

	localparam int NUM_NB     = 8;
	localparam int PH_W       = 32;
	localparam int WRAP_W     = 16;
	localparam int CNT_W      = 4;
	localparam int GAIN_W     = 16;
	localparam int GAIN_SHIFT = 14;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

	// sums of eight terms grow by three bits
	localparam int SUMU_W = PH_W + 3;
	localparam int SUMD_W = WRAP_W + 3;

	localparam int DIV_STEP   = 8;
	localparam int DIV_STAGES = (SUMU_W + DIV_STEP - 1) / DIV_STEP;

	localparam int AVG_W   = SUMU_W + 1;
	localparam int MDIFF_W = SUMD_W + 1;
	localparam int PROD_W  = MDIFF_W + GAIN_W + 1;
	localparam int CORR_W  = PROD_W - GAIN_SHIFT;

	typedef struct packed {
		logic [CNT_W-1:0]         count;
		logic signed [WRAP_W-1:0] center;
		logic                     neg_u;
		logic                     neg_d;
	} side_t;

endpackage

// ===== rtl/core/pup_lane.sv =====
module pup_lane (
	input  logic                               clk,
	input  logic                               en,
	input  logic                               use_nb,
	input  logic signed [pup_pkg::WRAP_W-1:0]  center,
	input  logic signed [pup_pkg::PH_W-1:0]    phase,
	output logic signed [pup_pkg::PH_W-1:0]    phase_s1,
	output logic signed [pup_pkg::WRAP_W-1:0]  diff_s1
);
	import pup_pkg::*;

	logic signed [WRAP_W-1:0] diff;

	// wrapped difference keeps only the low bits
	assign diff = center - $signed(phase[WRAP_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= use_nb ? phase : '0;
			diff_s1  <= use_nb ? diff : '0;
		end
	end

endmodule

// ===== rtl/core/pup_merge.sv =====
module pup_merge (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [pup_pkg::PH_W-1:0]    phase [pup_pkg::NUM_NB],
	input  logic signed [pup_pkg::WRAP_W-1:0]  diff [pup_pkg::NUM_NB],
	output logic signed [pup_pkg::SUMU_W-1:0]  sum_u_s4,
	output logic signed [pup_pkg::SUMD_W-1:0]  sum_d_s4
);
	import pup_pkg::*;

	logic signed [PH_W:0]     u_s2 [NUM_NB/2];
	logic signed [WRAP_W:0]   d_s2 [NUM_NB/2];
	logic signed [PH_W+1:0]   u_s3 [NUM_NB/4];
	logic signed [WRAP_W+1:0] d_s3 [NUM_NB/4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_NB/2; i++) begin
				u_s2[i] <= (PH_W+1)'(phase[2*i]) + (PH_W+1)'(phase[2*i+1]);
				d_s2[i] <= (WRAP_W+1)'(diff[2*i]) + (WRAP_W+1)'(diff[2*i+1]);
			end
			for (int i = 0; i < NUM_NB/4; i++) begin
				u_s3[i] <= (PH_W+2)'(u_s2[2*i]) + (PH_W+2)'(u_s2[2*i+1]);
				d_s3[i] <= (WRAP_W+2)'(d_s2[2*i]) + (WRAP_W+2)'(d_s2[2*i+1]);
			end
			sum_u_s4 <= SUMU_W'(u_s3[0]) + SUMU_W'(u_s3[1]);
			sum_d_s4 <= SUMD_W'(d_s3[0]) + SUMD_W'(d_s3[1]);
		end
	end

endmodule

// ===== rtl/core/pup_div.sv =====
module pup_div #(
	parameter int W = 35
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [W-1:0]                dividend,
	input  logic [pup_pkg::CNT_W-1:0]   divisor,
	output logic [W-1:0]                quotient
);
	import pup_pkg::*;

	localparam int STAGES = (W + DIV_STEP - 1) / DIV_STEP;
	localparam int PW     = STAGES * DIV_STEP;

	typedef struct packed {
		logic [PW-1:0]    work;
		logic [CNT_W-1:0] rem;
		logic [CNT_W-1:0] dvs;
	} div_st_t;

	// restoring steps on a divisor of at most eight: remainder stays narrow
	function automatic div_st_t div_steps(div_st_t a);
		div_st_t          r;
		logic [CNT_W-1:0] t;
		r = a;
		for (int i = 0; i < DIV_STEP; i++) begin
			t      = {r.rem[CNT_W-2:0], r.work[PW-1]};
			r.work = {r.work[PW-2:0], 1'b0};
			if (t >= r.dvs) begin
				t         = t - r.dvs;
				r.work[0] = 1'b1;
			end
			r.rem = t;
		end
		return r;
	endfunction

	div_st_t st_in [STAGES];
	div_st_t div_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign st_in[g] = '{work: PW'(dividend), rem: '0, dvs: divisor};
		end else begin : g_next
			assign st_in[g] = div_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g] <= div_steps(st_in[g]);
			end
		end
	end

	assign quotient = div_s[STAGES-1].work[W-1:0];

endmodule

// ===== rtl/core/phase_unwrap_pixel.sv =====
// phase_unwrap_pixel: one region-growing unwrap update per pixel word.
// input channel: in_valid/in_stall carries center_wrapped, the eight
//   neighbor phases up_phase_* and the neighbor_valid mask
// output channel: out_valid/out_stall carries unwrapped_phase,
//   used_count and saturated, one word per input word, in order
// config channel: cfg_valid/cfg_ready writes tau_gain; cfg_ready is
//   always high, write only while the block is empty
// throughput: one word per cycle while in_stall is low; the datapath
//   is fully pipelined (lanes, a three-level adder tree, a five-stage
//   divider of eight restoring steps each, multiply and final add)
// stall: a two-word output buffer; in_stall rises once the second slot
//   fills and the whole pipeline holds until out_stall drops
// reset: pipeline and buffer empty, tau_gain back to 1.0 (16384)
module phase_unwrap_pixel #(
	parameter int PHASE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pup_pkg::GAIN_W-1:0]          tau_gain,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pup_pkg::WRAP_W-1:0]   center_wrapped,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_n,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_s,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_w,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_e,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_se,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_ne,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_sw,
	input  logic signed [pup_pkg::PH_W-1:0]     up_phase_nw,
	input  logic [pup_pkg::NUM_NB-1:0]          neighbor_valid,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pup_pkg::PH_W-1:0]     unwrapped_phase,
	output logic [pup_pkg::CNT_W-1:0]           used_count,
	output logic                                saturated
);
	import pup_pkg::*;

	localparam int ST_ABS  = 5;
	localparam int ST_DIV  = ST_ABS + DIV_STAGES;
	localparam int ST_FIX  = ST_DIV + 1;
	localparam int ST_MUL  = ST_FIX + 1;
	localparam int LAST    = ST_MUL + 1;
	localparam int R_W     = (PHASE_BITS > AVG_W ? PHASE_BITS : AVG_W) + 2;
	localparam logic signed [R_W-1:0] PH_MAX =
		{{(R_W-PHASE_BITS+1){1'b0}}, {(PHASE_BITS-1){1'b1}}};
	localparam logic signed [R_W-1:0] PH_MIN =
		{{(R_W-PHASE_BITS+1){1'b1}}, {(PHASE_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [PH_W-1:0] phase;
		logic [CNT_W-1:0]       count;
		logic                   sat;
	} res_t;

	function automatic logic [CNT_W-1:0] pop8(logic [NUM_NB-1:0] m);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < NUM_NB; i++) begin
			c = c + CNT_W'(m[i]);
		end
		return c;
	endfunction

	logic                   adv;
	logic [GAIN_W-1:0]      tau_gain_q;
	logic [LAST:1]          vld_s;
	side_t                  side_s [1:LAST];

	logic signed [PH_W-1:0]   nb_phase [NUM_NB];
	logic signed [PH_W-1:0]   phase_s1 [NUM_NB];
	logic signed [WRAP_W-1:0] diff_s1 [NUM_NB];
	logic signed [SUMU_W-1:0] sum_u_s4;
	logic signed [SUMD_W-1:0] sum_d_s4;

	logic [SUMU_W-1:0]         mag_u_s5;
	logic [SUMD_W-1:0]         mag_d_s5;
	logic [SUMU_W-1:0]         q_u;
	logic [SUMU_W-1:0]         q_d;
	logic signed [AVG_W-1:0]   avg_s11;
	logic signed [AVG_W-1:0]   avg_s12;
	logic signed [AVG_W-1:0]   avg_s13;
	logic signed [MDIFF_W-1:0] mdiff_s11;
	logic signed [GAIN_W:0]    gain_sx;
	logic signed [PROD_W-1:0]  prod_s12;
	logic signed [CORR_W-1:0]  corr_s13;

	logic signed [R_W-1:0] r_sum;
	res_t                  res;
	logic                  push;
	logic                  out_valid_q;
	logic                  skid_valid_q;
	res_t                  out_q;
	res_t                  skid_q;

	// the whole pipeline moves unless the second buffer slot is taken
	assign adv       = !skid_valid_q;
	assign in_stall  = skid_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tau_gain_q <= tau_gain;
		end
	end

	assign nb_phase[0] = up_phase_n;
	assign nb_phase[1] = up_phase_s;
	assign nb_phase[2] = up_phase_w;
	assign nb_phase[3] = up_phase_e;
	assign nb_phase[4] = up_phase_se;
	assign nb_phase[5] = up_phase_ne;
	assign nb_phase[6] = up_phase_sw;
	assign nb_phase[7] = up_phase_nw;

	for (genvar k = 0; k < NUM_NB; k++) begin : g_lane
		pup_lane u_lane (
			.clk      (clk),
			.en       (adv),
			.use_nb   (neighbor_valid[k]),
			.center   (center_wrapped),
			.phase    (nb_phase[k]),
			.phase_s1 (phase_s1[k]),
			.diff_s1  (diff_s1[k])
		);
	end

	pup_merge u_merge (
		.clk      (clk),
		.en       (adv),
		.phase    (phase_s1),
		.diff     (diff_s1),
		.sum_u_s4 (sum_u_s4),
		.sum_d_s4 (sum_d_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= '{count: pop8(neighbor_valid), center: center_wrapped,
				neg_u: 1'b0, neg_d: 1'b0};
			for (int i = 2; i <= LAST; i++) begin
				if (i != ST_ABS) begin
					side_s[i] <= side_s[i-1];
				end
			end
			side_s[ST_ABS] <= '{count: side_s[ST_ABS-1].count,
				center: side_s[ST_ABS-1].center,
				neg_u: sum_u_s4[SUMU_W-1], neg_d: sum_d_s4[SUMD_W-1]};
			mag_u_s5 <= sum_u_s4[SUMU_W-1] ? SUMU_W'(-sum_u_s4) : SUMU_W'(sum_u_s4);
			mag_d_s5 <= sum_d_s4[SUMD_W-1] ? SUMD_W'(-sum_d_s4) : SUMD_W'(sum_d_s4);
		end
	end

	pup_div #(.W(SUMU_W)) u_div_u (
		.clk      (clk),
		.en       (adv),
		.dividend (mag_u_s5),
		.divisor  (side_s[ST_ABS].count),
		.quotient (q_u)
	);

	pup_div #(.W(SUMU_W)) u_div_d (
		.clk      (clk),
		.en       (adv),
		.dividend (SUMU_W'(mag_d_s5)),
		.divisor  (side_s[ST_ABS].count),
		.quotient (q_d)
	);

	assign gain_sx = $signed({1'b0, tau_gain_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			avg_s11   <= side_s[ST_DIV].neg_u ? -$signed({1'b0, q_u}) : $signed({1'b0, q_u});
			mdiff_s11 <= side_s[ST_DIV].neg_d ? -$signed({1'b0, q_d[SUMD_W-1:0]})
				: $signed({1'b0, q_d[SUMD_W-1:0]});
			avg_s12   <= avg_s11;
			prod_s12  <= mdiff_s11 * gain_sx;
			avg_s13   <= avg_s12;
			// divide by one in Q2.14, rounding toward zero
			corr_s13  <= prod_s12[PROD_W-1]
				? CORR_W'((prod_s12 + PROD_W'((1 << GAIN_SHIFT) - 1)) >>> GAIN_SHIFT)
				: CORR_W'(prod_s12 >>> GAIN_SHIFT);
		end
	end

	assign r_sum = R_W'(avg_s13) + R_W'(corr_s13);

	always_comb begin
		res.count = side_s[LAST].count;
		res.sat   = 1'b0;
		res.phase = r_sum[PH_W-1:0];
		if (side_s[LAST].count == '0) begin
			res.phase = PH_W'(side_s[LAST].center);
		end else if (r_sum > PH_MAX) begin
			res.phase = PH_MAX[PH_W-1:0];
			res.sat   = 1'b1;
		end else if (r_sum < PH_MIN) begin
			res.phase = PH_MIN[PH_W-1:0];
			res.sat   = 1'b1;
		end
	end

	assign push = adv && vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign unwrapped_phase = out_q.phase;
	assign used_count      = out_q.count;
	assign saturated       = out_q.sat;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held while output slot empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid slot filled without a stalled output");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_count <= CNT_W'(NUM_NB))
		else $error("used_count above neighbor count");

	a_sat_needs_nb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> used_count != '0)
		else $error("saturation flagged with no usable neighbor");
`endif

endmodule

// ===== tb/sv/tb_phase_unwrap_pixel.sv =====
module tb_phase_unwrap_pixel;
	timeunit 1ns;
	timeprecision 1ps;

	import pup_pkg::*;

	localparam int PHASE_BITS = 32;
	localparam int NUM_PHASES = 7;
	localparam int PHASE_ITEMS = 136;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic signed [WRAP_W-1:0]      center;
		logic [NUM_NB-1:0][PH_W-1:0]   nb;
		logic [NUM_NB-1:0]             mask;
	} pixel_t;

	typedef struct packed {
		logic [PH_W-1:0]  phase;
		logic [CNT_W-1:0] count;
		logic             sat;
	} estimate_t;

	// predicts one unwrap estimate per accepted pixel and checks them in order
	class unwrap_estimator;
		logic [GAIN_W-1:0] gain;
		estimate_t         pending_estimates[$];
		int unsigned       mismatches;

		function new();
			gain = GAIN_RESET;
			mismatches = 0;
		endfunction

		function void take_pixel(pixel_t p);
			longint    ctr, u, sum_u, sum_d, avg, mdiff, corr, r, hi, lo;
			int        n;
			logic [WRAP_W-1:0] dw;
			estimate_t e;
			ctr = longint'($signed(p.center));
			sum_u = 0;
			sum_d = 0;
			n = 0;
			e.sat = 1'b0;
			hi = (longint'(1) <<< (PHASE_BITS - 1)) - 1;
			lo = -hi - 1;
			for (int k = 0; k < NUM_NB; k++) begin
				if (p.mask[k]) begin
					u = longint'($signed(p.nb[k]));
					sum_u += u;
					dw = WRAP_W'(ctr - u);
					sum_d += longint'($signed(dw));
					n++;
				end
			end
			if (n == 0) begin
				r = ctr;
			end else begin
				avg = sum_u / n;
				mdiff = sum_d / n;
				corr = (longint'(gain) * mdiff) / (longint'(1) <<< GAIN_SHIFT);
				r = avg + corr;
				if (r > hi) begin
					r = hi;
					e.sat = 1'b1;
				end else if (r < lo) begin
					r = lo;
					e.sat = 1'b1;
				end
			end
			e.phase = r[PH_W-1:0];
			e.count = n[CNT_W-1:0];
			pending_estimates.push_back(e);
		endfunction

		function void match_estimate(estimate_t got);
			estimate_t want;
			if (pending_estimates.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word: phase %0d count %0d sat %0b",
						$signed(got.phase), got.count, got.sat);
				mismatches++;
				return;
			end
			want = pending_estimates.pop_front();
			if (got.phase !== want.phase || got.count !== want.count ||
					got.sat !== want.sat) begin
				if (mismatches < 10)
					$display("result mismatch: phase %0d/%0d count %0d/%0d sat %0b/%0b (exp/act)",
						$signed(want.phase), $signed(got.phase), want.count, got.count,
						want.sat, got.sat);
				mismatches++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [GAIN_W-1:0]        tau_gain;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [WRAP_W-1:0] center_wrapped;
	logic signed [PH_W-1:0]   up_phase_n, up_phase_s, up_phase_w, up_phase_e;
	logic signed [PH_W-1:0]   up_phase_se, up_phase_ne, up_phase_sw, up_phase_nw;
	logic [NUM_NB-1:0]        neighbor_valid;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [PH_W-1:0]   unwrapped_phase;
	logic [CNT_W-1:0]         used_count;
	logic                     saturated;

	unwrap_estimator est = new();

	int  rx_hold_len = 0;
	bit  rx_random = 1'b1;
	pixel_t    seen_pixel;
	estimate_t seen_estimate;

	phase_unwrap_pixel #(
		.PHASE_BITS(PHASE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.tau_gain(tau_gain),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.center_wrapped(center_wrapped),
		.up_phase_n(up_phase_n),
		.up_phase_s(up_phase_s),
		.up_phase_w(up_phase_w),
		.up_phase_e(up_phase_e),
		.up_phase_se(up_phase_se),
		.up_phase_ne(up_phase_ne),
		.up_phase_sw(up_phase_sw),
		.up_phase_nw(up_phase_nw),
		.neighbor_valid(neighbor_valid),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.unwrapped_phase(unwrapped_phase),
		.used_count(used_count),
		.saturated(saturated)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// sample handshakes with the values that stood before the edge
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_valid && cfg_ready)
				est.gain = tau_gain;
			if (in_valid && !in_stall) begin
				seen_pixel.center = center_wrapped;
				seen_pixel.nb[0] = up_phase_n;
				seen_pixel.nb[1] = up_phase_s;
				seen_pixel.nb[2] = up_phase_w;
				seen_pixel.nb[3] = up_phase_e;
				seen_pixel.nb[4] = up_phase_se;
				seen_pixel.nb[5] = up_phase_ne;
				seen_pixel.nb[6] = up_phase_sw;
				seen_pixel.nb[7] = up_phase_nw;
				seen_pixel.mask = neighbor_valid;
				est.take_pixel(seen_pixel);
			end
			if (out_valid && !out_stall) begin
				seen_estimate.phase = unwrapped_phase;
				seen_estimate.count = used_count;
				seen_estimate.sat = saturated;
				est.match_estimate(seen_estimate);
			end
		end
	end

	// output side: random stall bursts, quiet stretches and requested long holds
	initial begin : receiver
		int len;
		int r;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_len > 0) begin
				len = rx_hold_len;
				rx_hold_len = 0;
				out_stall <= 1'b1;
			end else if (!rx_random) begin
				len = 1;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					len = $urandom_range(1, 8);
					out_stall <= 1'b0;
				end else if (r < 95) begin
					len = $urandom_range(1, 3);
					out_stall <= 1'b1;
				end else begin
					len = $urandom_range(10, 30);
					out_stall <= 1'b1;
				end
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic pixel_t uniform_pixel(logic [WRAP_W-1:0] c, logic [NUM_NB-1:0] m,
			logic [PH_W-1:0] v);
		pixel_t p;
		p.center = c;
		p.mask = m;
		for (int k = 0; k < NUM_NB; k++)
			p.nb[k] = v;
		return p;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t      p;
		logic [31:0] base;
		int          kind;
		int          off;
		int          r;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			// neighbors close to a common phase, the usual case in a smooth map
			if (kind < 60)
				base = $urandom;
			else
				base = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000) +
					32'($urandom_range(0, 65535));
			for (int k = 0; k < NUM_NB; k++) begin
				off = int'($urandom_range(0, 80000)) - 40000;
				p.nb[k] = base + 32'(off);
			end
			off = int'($urandom_range(0, 40000)) - 20000;
			p.center = base[15:0] + 16'(off);
		end else begin
			p.center = 16'($urandom);
			for (int k = 0; k < NUM_NB; k++)
				p.nb[k] = $urandom;
		end
		r = $urandom_range(0, 99);
		if (r < 70)
			p.mask = 8'($urandom);
		else if (r < 80)
			p.mask = 8'hFF;
		else if (r < 90)
			p.mask = 8'h00;
		else
			p.mask = 8'(1 << $urandom_range(0, 7));
		return p;
	endfunction

	function automatic int pick_gap(bit idle_on);
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pixel(pixel_t p, bit idle_on);
		int g;
		in_valid <= 1'b1;
		center_wrapped <= p.center;
		up_phase_n <= p.nb[0];
		up_phase_s <= p.nb[1];
		up_phase_w <= p.nb[2];
		up_phase_e <= p.nb[3];
		up_phase_se <= p.nb[4];
		up_phase_ne <= p.nb[5];
		up_phase_sw <= p.nb[6];
		up_phase_nw <= p.nb[7];
		neighbor_valid <= p.mask;
		do @(posedge clk); while (in_stall);
		g = pick_gap(idle_on);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (est.pending_estimates.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(logic [GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		tau_gain <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		pixel_t            p;
		pixel_t            directed[$];
		logic [GAIN_W-1:0] gain_plan[NUM_PHASES];
		bit                idle_on;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		tau_gain <= GAIN_RESET;
		in_valid <= 1'b0;
		center_wrapped <= '0;
		up_phase_n <= '0;
		up_phase_s <= '0;
		up_phase_w <= '0;
		up_phase_e <= '0;
		up_phase_se <= '0;
		up_phase_ne <= '0;
		up_phase_sw <= '0;
		up_phase_nw <= '0;
		neighbor_valid <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no usable neighbor: the center comes back sign-extended
		directed.push_back(uniform_pixel(16'h8000, 8'h00, 32'hDEAD_BEEF));
		directed.push_back(uniform_pixel(16'h7FFF, 8'h00, 32'h1234_5678));
		directed.push_back(uniform_pixel(16'h0000, 8'h00, 32'h0000_0000));
		// one neighbor at a time, the others carry junk
		for (int k = 0; k < NUM_NB; k++) begin
			p = uniform_pixel(16'(16'h1111 * (k + 1)), 8'(1 << k), 32'h5A5A_5A5A);
			p.nb[k] = 32'(32'h0001_0000 * (k + 1) + 1000 * k);
			directed.push_back(p);
		end
		// clipped at the top and at the bottom
		directed.push_back(uniform_pixel(16'h0000, 8'hFF, 32'h7FFF_C000));
		directed.push_back(uniform_pixel(16'hFFFF, 8'hFF, 32'h8000_4000));
		directed.push_back(uniform_pixel(16'h7FFF, 8'hFF, 32'h7FFF_FFFF));
		directed.push_back(uniform_pixel(16'h8000, 8'hFF, 32'h8000_0000));
		// differences that wrap, the first exactly onto the negative limit
		directed.push_back(uniform_pixel(16'h0000, 8'h01, 32'h0000_8000));
		directed.push_back(uniform_pixel(16'h7FFF, 8'h01, 32'hFFFF_8000));
		// a negative sum that does not divide evenly, an even split, random neighbors
		p = uniform_pixel(16'h0000, 8'h07, 32'hFFFF_FFFF);
		p.nb[2] = 32'hFFFF_FFFE;
		directed.push_back(p);
		directed.push_back(uniform_pixel(16'h0005, 8'hAA, 32'h0000_0003));
		p = uniform_pixel(16'h4000, 8'h55, 32'h0000_0000);
		for (int k = 0; k < NUM_NB; k++)
			p.nb[k] = $urandom;
		directed.push_back(p);
		foreach (directed[i])
			send_pixel(directed[i], 1'b1);

		gain_plan[0] = 16'd0;
		gain_plan[1] = 16'hFFFF;
		gain_plan[2] = 16'd1;
		gain_plan[3] = 16'($urandom);
		gain_plan[4] = GAIN_RESET;
		gain_plan[5] = 16'h8000;
		gain_plan[6] = 16'($urandom);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			write_gain(gain_plan[ph]);
			idle_on = !(ph == 1 || ph == 2);
			rx_random = (ph != 2);
			// long output hold while words keep coming, so the block backs up
			if (ph == 1)
				rx_hold_len = 120;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 3 && i == 60)
					wait_drained();
				send_pixel(random_pixel(), idle_on);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (est.pending_estimates.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (est.mismatches == 0 && est.pending_estimates.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
